>>> design/dqs_pkg.sv
package dqs_pkg;

	// Item opcodes
	typedef enum logic [1:0] {
		OP_DOORBELL   = 2'd0,
		OP_SELECT     = 2'd1,
		OP_COMPLETION = 2'd2,
		OP_SET_TIME   = 2'd3
	} op_t;

	// Sequencer states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_ACCESS = 4'b0010,
		ST_UPDATE = 4'b0100,
		ST_SCAN   = 4'b1000
	} state_t;

	// Configuration register indexes
	localparam logic REG_ACTIVE_QUEUES = 1'b0;
	localparam logic REG_MAX_BURST     = 1'b1;

	localparam int          QUEUE_TOTAL_DEFAULT = 16;
	localparam logic [4:0]  RESET_ACTIVE        = 5'd16;
	localparam logic [15:0] RESET_MAX_BURST     = 16'd512;

endpackage

>>> design/doorbell_queue_scheduler.sv
// Doorbell, completion, set-time: state ACCESS does one memory read, then state UPDATE does
// one update and write; done is registered from UPDATE, one transaction at a time.
// Select: scan one queue per cycle on the shared read port and compare unit; done comes
// after the first eligible queue scanned, or after the last of the clamped active queues.
// Busy stays high until the done cycle; the next start is taken there. Results never stall.
// Reset (arst_n low, asynchronous): counts/times zero, pointer 0, active 16, max_burst 512.
module doorbell_queue_scheduler #(
	parameter int QUEUE_TOTAL = dqs_pkg::QUEUE_TOTAL_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	// command side
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [3:0]  queue,
	input  logic [15:0] pkt_count,
	input  logic [63:0] now,
	input  logic [63:0] ready_at,
	// result side
	output logic        done,
	output logic        granted,
	output logic [3:0]  grant_queue,
	output logic [15:0] grant_burst
);

	// PW: queue address bits, CW: bits for a count of queues, AW: width to clamp active_queues
	localparam int PW = (QUEUE_TOTAL > 1) ? $clog2(QUEUE_TOTAL) : 1;
	localparam int CW = $clog2(QUEUE_TOTAL + 1);
	localparam int AW = (CW > 5) ? CW : 5;

	// Configuration registers
	logic [4:0]  active_q;
	logic [15:0] max_burst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= dqs_pkg::RESET_ACTIVE;
			max_burst_q <= dqs_pkg::RESET_MAX_BURST;
		end else if (cfg_we) begin
			case (cfg_index)
				dqs_pkg::REG_ACTIVE_QUEUES: active_q    <= cfg_data[4:0];
				dqs_pkg::REG_MAX_BURST:     max_burst_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Per-queue state: two memories, valid bits mark entries written since reset
	logic [31:0] cnt_mem [QUEUE_TOTAL];
	logic [63:0] tim_mem [QUEUE_TOTAL];
	logic [QUEUE_TOTAL-1:0] cnt_vld_q;
	logic [QUEUE_TOTAL-1:0] tim_vld_q;

	// Sequencer and latched transaction
	dqs_pkg::state_t state_q, state_d;
	dqs_pkg::op_t    op_q;
	logic [PW-1:0]   qa_q;
	logic            in_range_q;
	logic [15:0]     cnt_q;
	logic [63:0]     now_q;
	logic [63:0]     ready_q;
	logic [CW-1:0]   act_q;
	logic [PW-1:0]   ptr_q, ptr_d;
	logic [PW-1:0]   idx_q, idx_d;
	logic [CW-1:0]   issued_q, issued_d;
	logic [CW-1:0]   evald_q, evald_d;

	// Read port
	logic            rd_en;
	logic [PW-1:0]   rd_addr;
	logic [31:0]     cnt_rd_q;
	logic [63:0]     tim_rd_q;
	logic            cv_rd_q, tv_rd_q;
	logic [PW-1:0]   rd_idx_q;
	logic            rd_vld_q, rd_vld_d;

	// Write port
	logic            wr_cnt_en, wr_tim_en;
	logic [31:0]     wr_cnt_data;

	// Finish of a transaction
	logic            fin, fin_grant;
	logic [PW-1:0]   fin_queue;
	logic [15:0]     fin_burst;

	// Result registers
	logic            done_q, granted_q;
	logic [3:0]      grant_queue_q;
	logic [15:0]     grant_burst_q;

	logic            accept;
	logic [AW-1:0]   act_wide;
	logic [CW-1:0]   act_in;
	logic [PW-1:0]   ptr_start;
	logic [31:0]     cur_cnt;
	logic [63:0]     cur_tim;
	logic            cnt_pos;
	logic [CW-1:0]   idx_inc;

	assign busy   = !state_q[$clog2(dqs_pkg::ST_IDLE)];
	assign accept = start && !busy;

	// Clamp the active count to 1..QUEUE_TOTAL and restart an out-of-range pointer
	always_comb begin
		act_wide = AW'(active_q);
		if (act_wide == '0) begin
			act_in = CW'(1);
		end else if (act_wide > AW'(QUEUE_TOTAL)) begin
			act_in = CW'(QUEUE_TOTAL);
		end else begin
			act_in = CW'(act_wide);
		end
		ptr_start = (CW'(ptr_q) >= act_in) ? '0 : ptr_q;
	end

	// Entries never written read as zero
	assign cur_cnt = cv_rd_q ? cnt_rd_q : '0;
	assign cur_tim = tv_rd_q ? tim_rd_q : '0;
	assign cnt_pos = (cur_cnt != '0) && !cur_cnt[31];
	assign idx_inc = CW'(idx_q) + CW'(1);

	always_comb begin
		state_d     = state_q;
		ptr_d       = ptr_q;
		idx_d       = idx_q;
		issued_d    = issued_q;
		evald_d     = evald_q;
		rd_en       = 1'b0;
		rd_addr     = idx_q;
		rd_vld_d    = 1'b0;
		wr_cnt_en   = 1'b0;
		wr_tim_en   = 1'b0;
		wr_cnt_data = cur_cnt;
		fin         = 1'b0;
		fin_grant   = 1'b0;
		fin_queue   = '0;
		fin_burst   = '0;
		case (state_q)
			dqs_pkg::ST_IDLE: begin
				if (accept) begin
					state_d  = (dqs_pkg::op_t'(op) == dqs_pkg::OP_SELECT) ?
						dqs_pkg::ST_SCAN : dqs_pkg::ST_ACCESS;
					idx_d    = ptr_start;
					issued_d = '0;
					evald_d  = '0;
				end
			end
			dqs_pkg::ST_ACCESS: begin
				rd_en   = 1'b1;
				rd_addr = qa_q;
				state_d = dqs_pkg::ST_UPDATE;
			end
			dqs_pkg::ST_UPDATE: begin
				fin     = 1'b1;
				state_d = dqs_pkg::ST_IDLE;
				if (in_range_q) begin
					case (op_q)
						dqs_pkg::OP_DOORBELL: begin
							wr_cnt_en   = 1'b1;
							wr_cnt_data = cur_cnt + {16'd0, cnt_q};
							// grant at once when eligible, burst from this doorbell
							if (cur_tim <= now_q) begin
								fin_grant = 1'b1;
								fin_queue = qa_q;
								fin_burst = (cnt_q > max_burst_q) ? max_burst_q : cnt_q;
							end
						end
						dqs_pkg::OP_COMPLETION: begin
							wr_cnt_en   = 1'b1;
							wr_cnt_data = cur_cnt - {16'd0, cnt_q};
						end
						dqs_pkg::OP_SET_TIME: begin
							wr_tim_en = 1'b1;
						end
						default: ;
					endcase
				end
			end
			dqs_pkg::ST_SCAN: begin
				// Evaluate the queue read last cycle, issue the next read behind it
				if (rd_vld_q) begin
					evald_d = evald_q + CW'(1);
				end
				if (rd_vld_q && cnt_pos && (cur_tim < now_q)) begin
					fin       = 1'b1;
					fin_grant = 1'b1;
					fin_queue = rd_idx_q;
					fin_burst = (cur_cnt > {16'd0, max_burst_q}) ? max_burst_q : cur_cnt[15:0];
					ptr_d     = rd_idx_q;
					state_d   = dqs_pkg::ST_IDLE;
				end else if (rd_vld_q && (evald_q + CW'(1) == act_q)) begin
					// every active queue checked, pointer holds
					fin     = 1'b1;
					state_d = dqs_pkg::ST_IDLE;
				end else if (issued_q != act_q) begin
					rd_en    = 1'b1;
					rd_addr  = idx_q;
					rd_vld_d = 1'b1;
					idx_d    = (idx_inc == act_q) ? '0 : PW'(idx_inc);
					issued_d = issued_q + CW'(1);
				end
			end
			default: begin
				state_d = dqs_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dqs_pkg::ST_IDLE;
			ptr_q     <= '0;
			idx_q     <= '0;
			issued_q  <= '0;
			evald_q   <= '0;
			rd_vld_q  <= 1'b0;
			cnt_vld_q <= '0;
			tim_vld_q <= '0;
			done_q    <= 1'b0;
			granted_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			ptr_q    <= ptr_d;
			idx_q    <= idx_d;
			issued_q <= issued_d;
			evald_q  <= evald_d;
			rd_vld_q <= rd_vld_d;
			if (wr_cnt_en) begin
				cnt_vld_q[qa_q] <= 1'b1;
			end
			if (wr_tim_en) begin
				tim_vld_q[qa_q] <= 1'b1;
			end
			done_q    <= fin;
			granted_q <= fin && fin_grant;
		end
	end

	// Latch the transaction and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= dqs_pkg::op_t'(op);
			qa_q       <= PW'(queue);
			in_range_q <= ({28'd0, queue} < 32'(QUEUE_TOTAL));
			cnt_q      <= pkt_count;
			now_q      <= now;
			ready_q    <= ready_at;
			act_q      <= act_in;
		end
		if (fin) begin
			grant_queue_q <= 4'(fin_queue);
			grant_burst_q <= fin_burst;
		end
	end

	// Queue memories: one registered read, one write per cycle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			cnt_rd_q <= cnt_mem[rd_addr];
			tim_rd_q <= tim_mem[rd_addr];
			cv_rd_q  <= cnt_vld_q[rd_addr];
			tv_rd_q  <= tim_vld_q[rd_addr];
			rd_idx_q <= rd_addr;
		end
		if (wr_cnt_en) begin
			cnt_mem[qa_q] <= wr_cnt_data;
		end
		if (wr_tim_en) begin
			tim_mem[qa_q] <= ready_q;
		end
	end

	assign done        = done_q;
	assign granted     = granted_q;
	assign grant_queue = grant_queue_q;
	assign grant_burst = grant_burst_q;

	// Checks
	a_grant_in_done: assert property (@(posedge clk) disable iff (!arst_n)
		granted |-> done)
		else $error("grant outside a done strobe");

	a_no_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !granted) |-> (grant_queue == 4'd0 && grant_burst == 16'd0))
		else $error("no-grant result carries nonzero fields");

	a_burst_clipped: assert property (@(posedge clk) disable iff (!arst_n)
		(done && granted) |-> (grant_burst <= max_burst_q))
		else $error("burst above max_burst");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done strobe without a transaction in flight");

endmodule

>>> sim/doorbell_queue_scheduler_tb.sv
`timescale 1ns / 100ps

module doorbell_queue_scheduler_tb;

	localparam int NQ          = dqs_pkg::QUEUE_TOTAL_DEFAULT;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASE_ITEMS = 200;

	// One command transaction as it goes to the block
	typedef struct {
		dqs_pkg::op_t op;
		logic [3:0]   qid;
		logic [15:0]  cnt;
		logic [63:0]  now;
		logic [63:0]  ready;
	} cmd_t;

	// One grant transaction as it comes back
	typedef struct {
		logic        granted;
		logic [3:0]  qid;
		logic [15:0] burst;
	} grant_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = dqs_pkg::REG_ACTIVE_QUEUES;
	logic [15:0] cfg_data = '0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  op = dqs_pkg::OP_DOORBELL;
	logic [3:0]  queue = '0;
	logic [15:0] pkt_count = '0;
	logic [63:0] now = '0;
	logic [63:0] ready_at = '0;
	logic        done;
	logic        granted;
	logic [3:0]  grant_queue;
	logic [15:0] grant_burst;

	doorbell_queue_scheduler dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.op(op),
		.queue(queue),
		.pkt_count(pkt_count),
		.now(now),
		.ready_at(ready_at),
		.done(done),
		.granted(granted),
		.grant_queue(grant_queue),
		.grant_burst(grant_burst)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Scheduler state as the testbench tracks it
	logic [31:0] pend_cnt [NQ];
	logic [63:0] elig_at [NQ];
	int          scan_ptr;
	logic [4:0]  act_reg = dqs_pkg::RESET_ACTIVE;
	logic [15:0] burst_cap = dqs_pkg::RESET_MAX_BURST;

	cmd_t   cmd_backlog [$];
	grant_t due_grants [$];
	int     fail_cnt = 0;
	int     cycle_cnt = 0;

	initial begin
		for (int i = 0; i < NQ; i++) begin
			pend_cnt[i] = '0;
			elig_at[i] = '0;
		end
		scan_ptr = 0;
	end

	// Apply one command to the tracked state and return the grant it yields.
	function automatic grant_t compute_grant(cmd_t c);
		grant_t g;
		int     span;
		int     idx;
		bit     found;
		g = '{granted: 1'b0, qid: 4'd0, burst: 16'd0};
		found = 1'b0;
		case (c.op)
			dqs_pkg::OP_SELECT: begin
				// Clamp the active count, then restart at 0 on a stale pointer
				span = (act_reg == 0) ? 1 : ((act_reg > NQ) ? NQ : act_reg);
				idx = (scan_ptr >= span) ? 0 : scan_ptr;
				for (int k = 0; k < span; k++) begin
					if (!found && pend_cnt[idx] != 0 && !pend_cnt[idx][31]
							&& elig_at[idx] < c.now) begin
						found = 1'b1;
						g.granted = 1'b1;
						g.qid = idx[3:0];
						g.burst = (pend_cnt[idx] > {16'd0, burst_cap}) ?
							burst_cap : pend_cnt[idx][15:0];
						scan_ptr = idx;
					end
					if (!found)
						idx = (idx + 1 == span) ? 0 : idx + 1;
				end
			end
			dqs_pkg::OP_DOORBELL: begin
				pend_cnt[c.qid] = pend_cnt[c.qid] + {16'd0, c.cnt};
				// Doorbell grants its own count, not the queue total
				if (elig_at[c.qid] <= c.now) begin
					g.granted = 1'b1;
					g.qid = c.qid;
					g.burst = (c.cnt > burst_cap) ? burst_cap : c.cnt;
				end
			end
			dqs_pkg::OP_COMPLETION: pend_cnt[c.qid] = pend_cnt[c.qid] - {16'd0, c.cnt};
			default: elig_at[c.qid] = c.ready;
		endcase
		return g;
	endfunction

	// Driver: bursts of back-to-back transactions separated by random gaps.
	// Start stays high until the block takes the transaction.
	cmd_t cur_cmd;
	cmd_t nxt_cmd;
	int   burst_left = 0;
	int   gap_left = 0;
	bit   launch;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			launch = 1'b0;
			if (start && !busy)
				due_grants.push_back(compute_grant(cur_cmd));
			// Hold the current transaction while the block is busy
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (cmd_backlog.size() > 0) begin
					if (burst_left == 0)
						burst_left = $urandom_range(1, 40);
					nxt_cmd = cmd_backlog.pop_front();
					burst_left--;
					launch = 1'b1;
					if (burst_left == 0)
						gap_left = ($urandom_range(0, 3) == 0) ?
							$urandom_range(5, 25) : $urandom_range(0, 3);
				end
				start <= launch;
				if (launch) begin
					cur_cmd = nxt_cmd;
					op <= nxt_cmd.op;
					queue <= nxt_cmd.qid;
					pkt_count <= nxt_cmd.cnt;
					now <= nxt_cmd.now;
					ready_at <= nxt_cmd.ready;
				end
			end
		end
	end

	// Monitor: every done strobe must match the oldest outstanding grant.
	grant_t want;

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (due_grants.size() == 0) begin
				$error("unexpected result: granted=%0d grant_queue=%0d grant_burst=%0d",
					granted, grant_queue, grant_burst);
				fail_cnt++;
			end else begin
				want = due_grants.pop_front();
				if (granted !== want.granted) begin
					$error("granted: expected %0d, got %0d", want.granted, granted);
					fail_cnt++;
				end
				if (grant_queue !== want.qid) begin
					$error("grant_queue: expected %0d, got %0d", want.qid, grant_queue);
					fail_cnt++;
				end
				if (grant_burst !== want.burst) begin
					$error("grant_burst: expected %0d, got %0d", want.burst, grant_burst);
					fail_cnt++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("doorbell_queue_scheduler test failed");
			$finish;
		end
	end

	task automatic push_cmd(dqs_pkg::op_t o, logic [3:0] q, logic [15:0] c, logic [63:0] t,
			logic [63:0] r);
		cmd_t item;
		item.op = o;
		item.qid = q;
		item.cnt = c;
		item.now = t;
		item.ready = r;
		cmd_backlog.push_back(item);
	endtask

	// Wait until the sender is empty and every grant is back, then let the block settle.
	task automatic wait_drained();
		do @(negedge clk);
		while (cmd_backlog.size() != 0 || start || due_grants.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Write both registers while the block is idle; track them in the model.
	task automatic write_cfg(logic [4:0] act, logic [15:0] cap);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= dqs_pkg::REG_ACTIVE_QUEUES;
		cfg_data <= {11'd0, act};
		@(posedge clk);
		cfg_index <= dqs_pkg::REG_MAX_BURST;
		cfg_data <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		act_reg = act;
		burst_cap = cap;
	endtask

	// Random traffic: mostly doorbell/select/completion on active queues around a
	// moving clock, so grants, misses and negative counts all show up.
	task automatic queue_traffic(int n, logic [4:0] act);
		logic [63:0]  t_cursor;
		logic [63:0]  t_item;
		logic [63:0]  r_item;
		logic [15:0]  c_item;
		logic [3:0]   q_item;
		dqs_pkg::op_t o_item;
		int           span;
		int           roll;
		span = (act == 0) ? 1 : ((act > NQ) ? NQ : act);
		case ($urandom_range(0, 2))
			0: t_cursor = 64'($urandom_range(0, 50));
			1: t_cursor = {$urandom, $urandom};
			default: t_cursor = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 400));
		endcase
		for (int i = 0; i < n; i++) begin
			t_cursor = t_cursor + 64'($urandom_range(0, 3));
			roll = $urandom_range(0, 99);
			if (roll < 30)
				o_item = dqs_pkg::OP_DOORBELL;
			else if (roll < 65)
				o_item = dqs_pkg::OP_SELECT;
			else if (roll < 85)
				o_item = dqs_pkg::OP_COMPLETION;
			else
				o_item = dqs_pkg::OP_SET_TIME;
			q_item = ($urandom_range(0, 4) == 0) ? 4'($urandom) :
				4'($urandom_range(0, span - 1));
			roll = $urandom_range(0, 99);
			if (roll < 70)
				c_item = 16'($urandom_range(0, 40));
			else if (roll < 85)
				c_item = 16'($urandom);
			else
				c_item = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			// Keep eligibility times near the clock, some ahead and some behind
			r_item = t_cursor + 64'($urandom_range(0, 16)) - 64'd6;
			t_item = t_cursor;
			if ($urandom_range(0, 9) == 0)
				t_item = {$urandom, $urandom};
			if ($urandom_range(0, 9) == 0)
				r_item = {$urandom, $urandom};
			push_cmd(o_item, q_item, c_item, t_item, r_item);
		end
	endtask

	localparam logic [63:0] T_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] T_MID = 64'h8000_0000_0000_0000;

	logic [4:0]  ph_act [8];
	logic [15:0] ph_cap [8];

	initial begin
		ph_act = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd17, 5'd1, 5'd16, 5'd0};
		ph_cap = '{16'hFFFF, 16'd0, 16'd7, 16'd1, 16'd300, 16'hFFFF, 16'd512, 16'd0};
		// Last phase picks a random setting
		ph_act[7] = 5'($urandom_range(0, 31));
		ph_cap[7] = 16'($urandom);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty select, zero and full counts, eligibility at the limits,
		// negative counts, clipping, and a pointer left high for the next phase.
		push_cmd(dqs_pkg::OP_SELECT, 4'd0, 16'd0, 64'd0, 64'd0);
		push_cmd(dqs_pkg::OP_DOORBELL, 4'd0, 16'd0, 64'd0, 64'd0);
		push_cmd(dqs_pkg::OP_DOORBELL, 4'd15, 16'hFFFF, T_MAX, 64'd0);
		push_cmd(dqs_pkg::OP_SET_TIME, 4'd3, 16'd0, 64'd0, T_MAX);
		push_cmd(dqs_pkg::OP_DOORBELL, 4'd3, 16'd5, T_MAX - 64'd1, 64'd0);
		push_cmd(dqs_pkg::OP_DOORBELL, 4'd3, 16'd1, T_MAX, 64'd0);
		push_cmd(dqs_pkg::OP_SELECT, 4'd0, 16'd0, T_MAX, 64'd0);
		push_cmd(dqs_pkg::OP_COMPLETION, 4'd15, 16'hFFFF, 64'd0, 64'd0);
		push_cmd(dqs_pkg::OP_COMPLETION, 4'd0, 16'd7, 64'd0, 64'd0);
		push_cmd(dqs_pkg::OP_DOORBELL, 4'd0, 16'd3, 64'd0, 64'd0);
		push_cmd(dqs_pkg::OP_SELECT, 4'd9, 16'd0, T_MAX, 64'd0);
		push_cmd(dqs_pkg::OP_SET_TIME, 4'd3, 16'd0, 64'd0, 64'd0);
		push_cmd(dqs_pkg::OP_SELECT, 4'd0, 16'd0, 64'd0, 64'd0);
		push_cmd(dqs_pkg::OP_SELECT, 4'd0, 16'd0, 64'd1, 64'd0);
		push_cmd(dqs_pkg::OP_COMPLETION, 4'd3, 16'd6, 64'd0, 64'd0);
		push_cmd(dqs_pkg::OP_SET_TIME, 4'd5, 16'd0, 64'd0, T_MID);
		push_cmd(dqs_pkg::OP_DOORBELL, 4'd5, 16'h5555, T_MID - 64'd1, 64'd0);
		push_cmd(dqs_pkg::OP_DOORBELL, 4'd5, 16'hAAAA, T_MID, 64'd0);
		push_cmd(dqs_pkg::OP_SELECT, 4'd0, 16'd0, T_MAX, T_MAX);

		// Each phase drains fully before the next write, so the sender pauses
		// until every grant is back at every boundary.
		for (int p = 0; p < 8; p++) begin
			wait_drained();
			write_cfg(ph_act[p], ph_cap[p]);
			@(negedge clk);
			queue_traffic(PHASE_ITEMS, ph_act[p]);
		end
		wait_drained();
		repeat (20) @(posedge clk);

		if (fail_cnt == 0)
			$display("doorbell_queue_scheduler test passed");
		else
			$display("doorbell_queue_scheduler test failed");
		$finish;
	end

endmodule
